// File: rtl/core/mecanum_inverse_kinematics_core_defines.svh
// ----------------------------------------------------------------------------
// Mecanum inverse kinematics core - assertion macros
// Shared concurrent assertion forms, sampled on clk with active-low rst_n.
// ----------------------------------------------------------------------------
`ifndef MECANUM_INVERSE_KINEMATICS_CORE_DEFINES_SVH
`define MECANUM_INVERSE_KINEMATICS_CORE_DEFINES_SVH

// same-cycle implication, off during reset
`define MIK_ASSERT_NOW(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (cons)) \
        else $error(msg);

// next-cycle implication, off during reset
`define MIK_ASSERT_NEXT(lbl, cond, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (cons)) \
        else $error(msg);

// checked on the edge after reset is seen low
`define MIK_ASSERT_IN_RESET(lbl, cons, msg) \
    lbl: assert property (@(posedge clk) !rst_n |=> (cons)) \
        else $error(msg);

`endif

// File: rtl/core/mik_pkg.sv
// ----------------------------------------------------------------------------
// mik_pkg
// Types, codes and constants shared by the mecanum inverse kinematics core.
// ----------------------------------------------------------------------------
package mik_pkg;

    localparam int FRAC_BITS_DEF = 16;
    localparam int ANGLE_FRAC    = 14;
    localparam int CFG_IDX_W     = 3;
    localparam int CFG_DATA_W    = 32;
    localparam int QUEUE_DEPTH   = 2;

    localparam logic KIND_REF  = 1'b0;
    localparam logic KIND_TICK = 1'b1;

    typedef enum logic [CFG_IDX_W-1:0] {
        REG_COS_OFFSET  = 3'd0,
        REG_SIN_OFFSET  = 3'd1,
        REG_BASE_OFF_X  = 3'd2,
        REG_BASE_OFF_Y  = 3'd3,
        REG_PROJ_SUM    = 3'd4,
        REG_INV_RADIUS  = 3'd5,
        REG_REF_TIMEOUT = 3'd6
    } cfg_reg_t;

    typedef enum logic [2:0] {
        ST_DRIVING   = 3'd0,
        ST_NO_REF    = 3'd1,
        ST_TIMED_OUT = 3'd2,
        ST_ACCEPTED  = 3'd3,
        ST_REJECTED  = 3'd4
    } status_t;

    typedef enum logic [1:0] {
        BK_IDLE,
        BK_RUN,
        BK_DONE
    } bk_state_t;

    typedef struct packed {
        status_t            status;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] yaw_rate;
    } cmd_t;

    typedef struct packed {
        logic signed [15:0] cos_angle;
        logic signed [15:0] sin_angle;
        logic signed [31:0] offset_x;
        logic signed [31:0] offset_y;
        logic [30:0]        proj_sum;
        logic [30:0]        inv_radius;
    } kin_cfg_t;

endpackage

// File: rtl/core/mik_if.sv
// ----------------------------------------------------------------------------
// mik_if
// Valid/ready channels for input items and wheel speed results.
// ----------------------------------------------------------------------------
interface mik_item_if;
    logic               valid;
    logic               ready;
    logic               kind;
    logic signed [31:0] vel_x;
    logic signed [31:0] vel_y;
    logic signed [31:0] yaw_rate;
    logic               ref_valid;
    logic [31:0]        stamp;
    logic [31:0]        now_time;

    modport source (
        output valid, kind, vel_x, vel_y, yaw_rate, ref_valid, stamp, now_time,
        input  ready
    );
    modport sink (
        input  valid, kind, vel_x, vel_y, yaw_rate, ref_valid, stamp, now_time,
        output ready
    );
endinterface

interface mik_result_if;
    logic               valid;
    logic               ready;
    logic signed [31:0] wheel_front_left;
    logic signed [31:0] wheel_front_right;
    logic signed [31:0] wheel_rear_right;
    logic signed [31:0] wheel_rear_left;
    logic [2:0]         status;

    modport source (
        output valid, wheel_front_left, wheel_front_right, wheel_rear_right,
               wheel_rear_left, status,
        input  ready
    );
    modport sink (
        input  valid, wheel_front_left, wheel_front_right, wheel_rear_right,
               wheel_rear_left, status,
        output ready
    );
endinterface

// File: rtl/core/mik_front.sv
// ----------------------------------------------------------------------------
// mik_front
// Takes input items, keeps the held reference and its age checks, and queues
// one command per item with a snapshot of the velocities to drive.
// ----------------------------------------------------------------------------
module mik_front
    import mik_pkg::*;
(
    input  logic        clk,
    input  logic        rst_n,
    mik_item_if.sink    item,
    input  logic [31:0] timeout,
    input  logic        q_full,
    output logic        push,
    output cmd_t        push_cmd
);

    logic signed [31:0] held_vel_x_reg, held_vel_x_next;
    logic signed [31:0] held_vel_y_reg, held_vel_y_next;
    logic signed [31:0] held_yaw_reg,   held_yaw_next;
    logic [31:0]        held_stamp_reg, held_stamp_next;
    logic               held_valid_reg, held_valid_next;

    logic [31:0] ref_stamp;
    logic [31:0] ref_age;
    logic        ref_ok;
    logic [31:0] held_age;
    logic        held_late;
    logic        accept;

    assign item.ready = !q_full;
    assign accept     = item.valid && item.ready;

    always_comb
    begin
        ref_stamp = (item.stamp == '0) ? item.now_time : item.stamp;
        ref_age   = item.now_time - ref_stamp;
        ref_ok    = (timeout == '0) || (ref_age <= timeout);
        held_age  = item.now_time - held_stamp_reg;
        held_late = held_age > timeout;

        held_vel_x_next = held_vel_x_reg;
        held_vel_y_next = held_vel_y_reg;
        held_yaw_next   = held_yaw_reg;
        held_stamp_next = held_stamp_reg;
        held_valid_next = held_valid_reg;

        push              = accept;
        push_cmd.vel_x    = held_vel_x_reg;
        push_cmd.vel_y    = held_vel_y_reg;
        push_cmd.yaw_rate = held_yaw_reg;
        push_cmd.status   = ST_DRIVING;

        if (item.kind == KIND_REF)
        begin
            push_cmd.status = ref_ok ? ST_ACCEPTED : ST_REJECTED;
            if (accept && ref_ok)
            begin
                held_vel_x_next = item.vel_x;
                held_vel_y_next = item.vel_y;
                held_yaw_next   = item.yaw_rate;
                held_stamp_next = ref_stamp;
                held_valid_next = item.ref_valid;
            end
        end
        else if (!held_valid_reg)
        begin
            push_cmd.status = ST_NO_REF;
        end
        else if (held_late)
        begin
            // zero timeout: drive once, then drop the reference
            push_cmd.status = (timeout != '0) ? ST_TIMED_OUT : ST_DRIVING;
            if (accept)
            begin
                held_valid_next = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            held_valid_reg <= 1'b0;
        end
        else
        begin
            held_valid_reg <= held_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        held_vel_x_reg <= held_vel_x_next;
        held_vel_y_reg <= held_vel_y_next;
        held_yaw_reg   <= held_yaw_next;
        held_stamp_reg <= held_stamp_next;
    end

endmodule

// File: rtl/core/mik_queue.sv
// ----------------------------------------------------------------------------
// mik_queue
// Short FIFO of commands between the front and the kinematics back end.
// ----------------------------------------------------------------------------
module mik_queue
    import mik_pkg::*;
(
    input  logic clk,
    input  logic rst_n,
    input  logic push,
    input  cmd_t push_cmd,
    output logic full,
    input  logic pop,
    output cmd_t pop_cmd,
    output logic not_empty
);

    localparam int PTR_W = (QUEUE_DEPTH > 1) ? $clog2(QUEUE_DEPTH) : 1;
    localparam int CNT_W = $clog2(QUEUE_DEPTH + 1);

    cmd_t             entry_reg [QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] count_reg,  count_next;

    function automatic logic [PTR_W-1:0] ptr_inc(input logic [PTR_W-1:0] p);
        logic [PTR_W-1:0] r;
        if (p == PTR_W'(QUEUE_DEPTH - 1))
        begin
            r = '0;
        end
        else
        begin
            r = p + PTR_W'(1);
        end
        return r;
    endfunction

    assign full      = (count_reg == CNT_W'(QUEUE_DEPTH));
    assign not_empty = (count_reg != '0);
    assign pop_cmd   = entry_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = push ? ptr_inc(wr_ptr_reg) : wr_ptr_reg;
        rd_ptr_next = pop  ? ptr_inc(rd_ptr_reg) : rd_ptr_reg;
        count_next  = count_reg;
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            entry_reg[wr_ptr_reg] <= push_cmd;
        end
    end

endmodule

// File: rtl/core/mik_back.sv
// ----------------------------------------------------------------------------
// mik_back
// Runs the kinematics of a drive command on one shared 33x33 multiplier,
// then saturates the four wheel speeds into the result register.
// ----------------------------------------------------------------------------
module mik_back
    import mik_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic        clk,
    input  logic        rst_n,
    input  kin_cfg_t    cfg,
    input  logic        q_valid,
    input  cmd_t        q_cmd,
    output logic        pop,
    mik_result_if.source result
);

    localparam int NUM_WHEELS = 4;
    localparam int MAG_W      = 57;

    localparam logic [4:0] SQ_COS_VX   = 5'd0;
    localparam logic [4:0] SQ_SIN_VY   = 5'd1;
    localparam logic [4:0] SQ_SIN_VX   = 5'd2;
    localparam logic [4:0] SQ_COS_VY   = 5'd3;
    localparam logic [4:0] SQ_OFFY_YAW = 5'd4;
    localparam logic [4:0] SQ_OFFX_YAW = 5'd5;
    localparam logic [4:0] SQ_PROJ_YAW = 5'd6;
    localparam logic [4:0] SQ_LEVER    = 5'd7;
    localparam logic [4:0] SQ_MIX      = 5'd8;
    localparam logic [4:0] SQ_MAG      = 5'd9;
    localparam logic [4:0] SQ_WHEEL    = 5'd10;
    localparam logic [4:0] SQ_LAST     = 5'd18;

    bk_state_t state_reg, state_next;
    logic [4:0] step_reg, step_next;
    logic       out_valid_reg, out_valid_next;
    logic       out_free;
    logic       load_pass;
    logic       load_drive;

    logic signed [31:0] vel_x_reg, vel_y_reg, yaw_reg;
    logic signed [63:0] prod_reg;
    logic signed [63:0] acc_reg;
    logic signed [63:0] vb_x_reg, vb_y_reg, vc_x_reg, vc_y_reg;
    logic signed [63:0] pw_reg, mix_d_reg, mix_e_reg;
    logic signed [63:0] sum_reg [NUM_WHEELS];
    logic [MAG_W-1:0]   mag_reg [NUM_WHEELS];
    logic [NUM_WHEELS-1:0] neg_reg;
    logic [63:0]        hp_reg;
    logic [32:0]        q_reg [NUM_WHEELS];

    logic signed [31:0] wheel_reg [NUM_WHEELS];
    status_t            status_reg;

    logic signed [32:0] mul_a, mul_b;
    logic signed [65:0] mul_full;
    logic [4:0]         issue_off, cons_off;
    logic [1:0]         issue_wheel, cons_wheel;
    logic               is_issue, is_cons;
    logic [63:0]        q_sum;
    logic [32:0]        q_sat;

    function automatic logic signed [63:0] shr_tz(input logic signed [63:0] x,
                                                  input int unsigned sh);
        logic [63:0] mask;
        logic        fix;
        mask = ~({64{1'b1}} << sh);
        fix  = x[63] && (|(x & mask));
        return (x >>> sh) + $signed(64'(fix));
    endfunction

    function automatic logic signed [31:0] clamp_wheel(input logic [32:0] q,
                                                       input logic neg);
        logic [32:0] qc;
        logic [31:0] r;
        if (neg)
        begin
            qc = (q > 33'h0_8000_0000) ? 33'h0_8000_0000 : q;
            r  = 32'h0 - qc[31:0];
        end
        else
        begin
            r = (q > 33'h0_7FFF_FFFF) ? 32'h7FFF_FFFF : q[31:0];
        end
        return r;
    endfunction

    assign issue_off   = step_reg - SQ_WHEEL;
    assign cons_off    = step_reg - (SQ_WHEEL + 5'd1);
    assign issue_wheel = issue_off[2:1];
    assign cons_wheel  = cons_off[2:1];
    assign is_issue    = (step_reg >= SQ_WHEEL) && (step_reg < SQ_LAST);
    assign is_cons     = (step_reg > SQ_WHEEL) && (step_reg <= SQ_LAST);

    // operand select for the shared multiplier
    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        case (step_reg)
            SQ_COS_VX:
            begin
                mul_a = 33'($signed(cfg.cos_angle));
                mul_b = 33'(vel_x_reg);
            end
            SQ_SIN_VY:
            begin
                mul_a = 33'($signed(cfg.sin_angle));
                mul_b = 33'(vel_y_reg);
            end
            SQ_SIN_VX:
            begin
                mul_a = 33'($signed(cfg.sin_angle));
                mul_b = 33'(vel_x_reg);
            end
            SQ_COS_VY:
            begin
                mul_a = 33'($signed(cfg.cos_angle));
                mul_b = 33'(vel_y_reg);
            end
            SQ_OFFY_YAW:
            begin
                mul_a = 33'($signed(cfg.offset_y));
                mul_b = 33'(yaw_reg);
            end
            SQ_OFFX_YAW:
            begin
                mul_a = 33'($signed(cfg.offset_x));
                mul_b = 33'(yaw_reg);
            end
            SQ_PROJ_YAW:
            begin
                mul_a = {2'b00, cfg.proj_sum};
                mul_b = 33'(yaw_reg);
            end
            default:
            begin
                if (is_issue)
                begin
                    mul_b = {2'b00, cfg.inv_radius};
                    if (issue_off[0])
                    begin
                        mul_a = {1'b0, mag_reg[issue_wheel][31:0]};
                    end
                    else
                    begin
                        mul_a = 33'(mag_reg[issue_wheel][MAG_W-1:32]);
                    end
                end
            end
        endcase
    end

    assign mul_full = mul_a * mul_b;

    // hi product saturates early; lo product completes the scaled magnitude
    always_comb
    begin
        q_sum = (hp_reg << (32 - FRAC_BITS)) + (64'(prod_reg) >> FRAC_BITS);
        if ((hp_reg >= (64'(1) << FRAC_BITS)) || (q_sum >= 64'h1_0000_0000))
        begin
            q_sat = 33'h1_0000_0000;
        end
        else
        begin
            q_sat = q_sum[32:0];
        end
    end

    always_comb
    begin
        state_next = state_reg;
        step_next  = step_reg;
        pop        = 1'b0;
        load_pass  = 1'b0;
        load_drive = 1'b0;
        out_free   = !out_valid_reg || result.ready;
        case (state_reg)
            BK_IDLE:
            begin
                if (q_valid)
                begin
                    if (q_cmd.status == ST_DRIVING)
                    begin
                        pop        = 1'b1;
                        state_next = BK_RUN;
                        step_next  = SQ_COS_VX;
                    end
                    else if (out_free)
                    begin
                        pop       = 1'b1;
                        load_pass = 1'b1;
                    end
                end
            end
            BK_RUN:
            begin
                step_next = step_reg + 5'd1;
                if (step_reg == SQ_LAST)
                begin
                    state_next = BK_DONE;
                end
            end
            BK_DONE:
            begin
                if (out_free)
                begin
                    load_drive = 1'b1;
                    state_next = BK_IDLE;
                end
            end
            default:
            begin
                state_next = BK_IDLE;
            end
        endcase
        out_valid_next = (out_valid_reg && !result.ready) || load_pass || load_drive;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= BK_IDLE;
            step_reg      <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            step_reg      <= step_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        if (pop && (q_cmd.status == ST_DRIVING))
        begin
            vel_x_reg <= q_cmd.vel_x;
            vel_y_reg <= q_cmd.vel_y;
            yaw_reg   <= q_cmd.yaw_rate;
        end
        if (state_reg == BK_RUN)
        begin
            prod_reg <= mul_full[63:0];
            case (step_reg)
                SQ_SIN_VY:
                begin
                    acc_reg <= prod_reg;
                end
                SQ_SIN_VX:
                begin
                    acc_reg <= acc_reg - prod_reg;
                end
                SQ_COS_VY:
                begin
                    vb_x_reg <= shr_tz(acc_reg, ANGLE_FRAC);
                    acc_reg  <= prod_reg;
                end
                SQ_OFFY_YAW:
                begin
                    acc_reg <= acc_reg + prod_reg;
                end
                SQ_OFFX_YAW:
                begin
                    vb_y_reg <= shr_tz(acc_reg, ANGLE_FRAC);
                    vc_x_reg <= vb_x_reg + shr_tz(prod_reg, FRAC_BITS);
                end
                SQ_PROJ_YAW:
                begin
                    vc_y_reg <= vb_y_reg - shr_tz(prod_reg, FRAC_BITS);
                end
                SQ_LEVER:
                begin
                    pw_reg    <= shr_tz(prod_reg, FRAC_BITS);
                    mix_d_reg <= vc_x_reg - vc_y_reg;
                    mix_e_reg <= vc_x_reg + vc_y_reg;
                end
                SQ_MIX:
                begin
                    sum_reg[0] <= mix_d_reg - pw_reg;
                    sum_reg[1] <= mix_e_reg + pw_reg;
                    sum_reg[2] <= mix_d_reg + pw_reg;
                    sum_reg[3] <= mix_e_reg - pw_reg;
                end
                SQ_MAG:
                begin
                    for (int k = 0; k < NUM_WHEELS; k++)
                    begin
                        neg_reg[k] <= sum_reg[k][63];
                        mag_reg[k] <= sum_reg[k][63] ? MAG_W'(-sum_reg[k])
                                                     : MAG_W'(sum_reg[k]);
                    end
                end
                default:
                begin
                    if (is_cons)
                    begin
                        if (cons_off[0])
                        begin
                            q_reg[cons_wheel] <= q_sat;
                        end
                        else
                        begin
                            hp_reg <= 64'(prod_reg);
                        end
                    end
                end
            endcase
        end
        if (load_drive)
        begin
            for (int k = 0; k < NUM_WHEELS; k++)
            begin
                wheel_reg[k] <= clamp_wheel(q_reg[k], neg_reg[k]);
            end
            status_reg <= ST_DRIVING;
        end
        else if (load_pass)
        begin
            for (int k = 0; k < NUM_WHEELS; k++)
            begin
                wheel_reg[k] <= '0;
            end
            status_reg <= q_cmd.status;
        end
    end

    assign result.valid             = out_valid_reg;
    assign result.wheel_front_left  = wheel_reg[0];
    assign result.wheel_front_right = wheel_reg[1];
    assign result.wheel_rear_right  = wheel_reg[2];
    assign result.wheel_rear_left   = wheel_reg[3];
    assign result.status            = status_reg;

endmodule

// File: rtl/core/mecanum_inverse_kinematics_core.sv
// ----------------------------------------------------------------------------
// mecanum_inverse_kinematics_core
// Mecanum wheel inverse kinematics with a held, age-checked velocity reference.
// ----------------------------------------------------------------------------
// Usage:
//   item   : valid/ready sink. kind 0 carries a velocity reference, kind 1 is
//            a control tick carrying now_time. Every item yields one result.
//   result : valid/ready source with four wheel speeds (Q16.16 by default)
//            and a status code.
//   cfg_*  : write port for the seven kinematics registers; write while idle.
// Flow:
//   Reference items and ticks that do not drive: queued, then loaded into the
//   result register; one item per cycle while no drive runs and the result is taken.
//   Driving ticks: worked through the 19-step sequence on the single shared
//   33x33 multiplier in the back end, which takes no new command until the
//   result of the drive is loaded.
//   A two-entry command queue sits between front and back end, so items keep
//   being taken while the back end works or the result waits.
// Reset: held reference invalid, queue empty, no result pending, registers at
//   their defaults (unit cos, zero sin and offsets, unit scale, timeout 0).
// Stall: the result register holds until transfer; once the queue is full the
//   item channel deasserts ready.
// ----------------------------------------------------------------------------
module mecanum_inverse_kinematics_core
    import mik_pkg::*;
#(
    parameter int FRAC_BITS = FRAC_BITS_DEF
)
(
    input  logic                  clk,
    input  logic                  rst_n,
    mik_item_if.sink              item,
    mik_result_if.source          result,
    input  logic                  cfg_we,
    input  logic [CFG_IDX_W-1:0]  cfg_index,
    input  logic [CFG_DATA_W-1:0] cfg_wdata
);

    logic signed [15:0] cos_reg;
    logic signed [15:0] sin_reg;
    logic signed [31:0] off_x_reg;
    logic signed [31:0] off_y_reg;
    logic [30:0]        proj_reg;
    logic [30:0]        inv_rad_reg;
    logic [31:0]        timeout_reg;

    kin_cfg_t kin_cfg;
    logic     push;
    cmd_t     push_cmd;
    logic     q_full;
    logic     pop;
    cmd_t     pop_cmd;
    logic     q_valid;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cos_reg     <= 16'sd16384;
            sin_reg     <= '0;
            off_x_reg   <= '0;
            off_y_reg   <= '0;
            proj_reg    <= 31'(1) << FRAC_BITS;
            inv_rad_reg <= 31'(1) << FRAC_BITS;
            timeout_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_reg_t'(cfg_index))
                REG_COS_OFFSET:  cos_reg     <= cfg_wdata[15:0];
                REG_SIN_OFFSET:  sin_reg     <= cfg_wdata[15:0];
                REG_BASE_OFF_X:  off_x_reg   <= cfg_wdata[31:0];
                REG_BASE_OFF_Y:  off_y_reg   <= cfg_wdata[31:0];
                REG_PROJ_SUM:    proj_reg    <= cfg_wdata[30:0];
                REG_INV_RADIUS:  inv_rad_reg <= cfg_wdata[30:0];
                REG_REF_TIMEOUT: timeout_reg <= cfg_wdata[31:0];
                default:
                begin
                end
            endcase
        end
    end

    always_comb
    begin
        kin_cfg.cos_angle  = cos_reg;
        kin_cfg.sin_angle  = sin_reg;
        kin_cfg.offset_x   = off_x_reg;
        kin_cfg.offset_y   = off_y_reg;
        kin_cfg.proj_sum   = proj_reg;
        kin_cfg.inv_radius = inv_rad_reg;
    end

    mik_front u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .item     (item),
        .timeout  (timeout_reg),
        .q_full   (q_full),
        .push     (push),
        .push_cmd (push_cmd)
    );

    mik_queue u_queue (
        .clk       (clk),
        .rst_n     (rst_n),
        .push      (push),
        .push_cmd  (push_cmd),
        .full      (q_full),
        .pop       (pop),
        .pop_cmd   (pop_cmd),
        .not_empty (q_valid)
    );

    mik_back #(
        .FRAC_BITS (FRAC_BITS)
    ) u_back (
        .clk     (clk),
        .rst_n   (rst_n),
        .cfg     (kin_cfg),
        .q_valid (q_valid),
        .q_cmd   (pop_cmd),
        .pop     (pop),
        .result  (result)
    );

endmodule

// File: rtl/core/mik_checker.sv
// ----------------------------------------------------------------------------
// mik_checker
// Port-level checks on the result channel of the kinematics core.
// ----------------------------------------------------------------------------
`include "mecanum_inverse_kinematics_core_defines.svh"

module mik_checker
    import mik_pkg::*;
(
    input logic        clk,
    input logic        rst_n,
    input logic        result_valid,
    input logic        result_ready,
    input logic [31:0] wheel_fl,
    input logic [31:0] wheel_fr,
    input logic [31:0] wheel_rr,
    input logic [31:0] wheel_rl,
    input logic [2:0]  status
);

    `MIK_ASSERT_IN_RESET(a_no_result_in_reset, !result_valid, "result valid during reset")

    `MIK_ASSERT_NEXT(a_result_holds,
        result_valid && !result_ready,
        result_valid && $stable(wheel_fl) && $stable(wheel_fr) && $stable(wheel_rr)
            && $stable(wheel_rl) && $stable(status),
        "stalled result changed")

    `MIK_ASSERT_NOW(a_idle_wheels_zero,
        result_valid && (status != ST_DRIVING),
        (wheel_fl == '0) && (wheel_fr == '0) && (wheel_rr == '0) && (wheel_rl == '0),
        "nonzero wheel speed on a non-driving result")

endmodule

bind mecanum_inverse_kinematics_core mik_checker u_mik_checker (
    .clk          (clk),
    .rst_n        (rst_n),
    .result_valid (result.valid),
    .result_ready (result.ready),
    .wheel_fl     (result.wheel_front_left),
    .wheel_fr     (result.wheel_front_right),
    .wheel_rr     (result.wheel_rear_right),
    .wheel_rl     (result.wheel_rear_left),
    .status       (result.status)
);

// File: bench/tb.sv
// ----------------------------------------------------------------------------
// tb
// Self-checking bench for mecanum_inverse_kinematics_core: directed reference
// and tick sequences, then random traffic under random register settings.
// Results are predicted per item and compared in order, with random
// idle and stall bursts on both channels.
// ----------------------------------------------------------------------------
module tb;
    import mik_pkg::*;

    localparam int FRAC        = FRAC_BITS_DEF;
    localparam int CYCLE_LIMIT = 600000;

    typedef struct {
        logic               kind;
        logic signed [31:0] vel_x;
        logic signed [31:0] vel_y;
        logic signed [31:0] yaw_rate;
        logic               ref_valid;
        logic [31:0]        stamp;
        logic [31:0]        now_time;
    } body_cmd_t;

    typedef struct {
        logic signed [31:0] fl;
        logic signed [31:0] fr;
        logic signed [31:0] rr;
        logic signed [31:0] rl;
        status_t            status;
    } wheel_out_t;

    logic                  clk;
    logic                  rst_n;
    logic                  cfg_we;
    logic [CFG_IDX_W-1:0]  cfg_index;
    logic [CFG_DATA_W-1:0] cfg_wdata;

    mik_item_if   item_ch();
    mik_result_if result_ch();

    mecanum_inverse_kinematics_core dut (
        .clk       (clk),
        .rst_n     (rst_n),
        .item      (item_ch),
        .result    (result_ch),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_wdata (cfg_wdata)
    );

    // predictor copy of registers and held reference
    logic signed [15:0] cos_a;
    logic signed [15:0] sin_a;
    logic signed [31:0] off_x;
    logic signed [31:0] off_y;
    logic [30:0]        proj;
    logic [30:0]        inv_r;
    logic [31:0]        ref_tmo;
    logic signed [31:0] held_vx;
    logic signed [31:0] held_vy;
    logic signed [31:0] held_yaw;
    logic [31:0]        held_stamp;
    logic               held_ok;

    wheel_out_t pending_wheels[$];
    int         mismatches = 0;
    int         cycles = 0;
    bit         steady = 1'b0;
    logic [31:0] now_t;

    initial
    begin
        clk = 1'b0;
        forever #2 clk = ~clk;
    end

    always @(posedge clk)
    begin
        cycles <= cycles + 1;
        if (cycles >= CYCLE_LIMIT)
        begin
            $display("TEST FAILED");
            $finish;
        end
    end

    function automatic longint trunc_shift(longint x, int s);
        longint unsigned m;
        m = (x < 0) ? -x : x;
        m = m >> s;
        return (x < 0) ? -longint'(m) : longint'(m);
    endfunction

    function automatic logic signed [31:0] wheel_scale(longint s, logic [30:0] inv);
        longint unsigned m, hi, lo, q, iv;
        iv = inv;
        m  = (s < 0) ? -s : s;
        hi = (m >> 32) * iv;
        lo = (m & 64'hFFFF_FFFF) * iv;
        if (hi >= (64'd1 << FRAC))
            q = 64'd1 << 32;
        else
            q = (hi << (32 - FRAC)) + (lo >> FRAC);
        if (s < 0)
        begin
            if (q > 64'h8000_0000)
                q = 64'h8000_0000;
            q = -q;
        end
        else if (q > 64'h7FFF_FFFF)
            q = 64'h7FFF_FFFF;
        return q[31:0];
    endfunction

    function automatic wheel_out_t predict_wheels(body_cmd_t c);
        wheel_out_t w;
        logic [31:0] st, age;
        longint vbx, vby, vcx, vcy, pw;
        w.fl = '0;
        w.fr = '0;
        w.rr = '0;
        w.rl = '0;
        if (c.kind == KIND_REF)
        begin
            st  = (c.stamp == 32'd0) ? c.now_time : c.stamp;
            age = c.now_time - st;
            if (ref_tmo == 32'd0 || age <= ref_tmo)
            begin
                held_vx    = c.vel_x;
                held_vy    = c.vel_y;
                held_yaw   = c.yaw_rate;
                held_stamp = st;
                held_ok    = c.ref_valid;
                w.status   = ST_ACCEPTED;
            end
            else
                w.status = ST_REJECTED;
            return w;
        end
        if (!held_ok)
        begin
            w.status = ST_NO_REF;
            return w;
        end
        age = c.now_time - held_stamp;
        if (age > ref_tmo)
        begin
            held_ok = 1'b0;
            if (ref_tmo != 32'd0)
            begin
                w.status = ST_TIMED_OUT;
                return w;
            end
        end
        vbx = trunc_shift(longint'(cos_a) * longint'(held_vx)
                          - longint'(sin_a) * longint'(held_vy), ANGLE_FRAC);
        vby = trunc_shift(longint'(sin_a) * longint'(held_vx)
                          + longint'(cos_a) * longint'(held_vy), ANGLE_FRAC);
        vcx = vbx + trunc_shift(longint'(off_y) * longint'(held_yaw), FRAC);
        vcy = vby - trunc_shift(longint'(off_x) * longint'(held_yaw), FRAC);
        pw  = trunc_shift(longint'(proj) * longint'(held_yaw), FRAC);
        w.fl     = wheel_scale(vcx - vcy - pw, inv_r);
        w.fr     = wheel_scale(vcx + vcy + pw, inv_r);
        w.rr     = wheel_scale(vcx - vcy + pw, inv_r);
        w.rl     = wheel_scale(vcx + vcy - pw, inv_r);
        w.status = ST_DRIVING;
        return w;
    endfunction

    function automatic logic signed [31:0] rand_wide();
        case ($urandom_range(0, 5))
            0: return $urandom;
            1: return 32'h7FFF_FFFF;
            2: return 32'h8000_0000;
            default: return int'($urandom_range(0, 1 << 21)) - (1 << 20);
        endcase
    endfunction

    function automatic body_cmd_t ref_cmd(input logic signed [31:0] vx, vy, yaw,
                                          input logic rv, input logic [31:0] stamp, now_v);
        body_cmd_t c;
        c.kind      = KIND_REF;
        c.vel_x     = vx;
        c.vel_y     = vy;
        c.yaw_rate  = yaw;
        c.ref_valid = rv;
        c.stamp     = stamp;
        c.now_time  = now_v;
        return c;
    endfunction

    function automatic body_cmd_t tick_cmd(logic [31:0] now_v);
        body_cmd_t c;
        c = ref_cmd($urandom, $urandom, $urandom, 1'($urandom), $urandom, now_v);
        c.kind = KIND_TICK;
        return c;
    endfunction

    // mostly coherent traffic around a running clock, some noise
    function automatic body_cmd_t random_cmd();
        body_cmd_t c;
        int pick;
        pick = $urandom_range(0, 99);
        c = ref_cmd(rand_wide(), rand_wide(), rand_wide(), $urandom_range(0, 9) != 0,
                    $urandom, now_t);
        if (pick < 45)
        begin
            now_t = now_t + $urandom_range(0, 6);
            c = tick_cmd(now_t);
        end
        else if (pick < 88)
        begin
            c.stamp = now_t - $urandom_range(0, 45);
            if ($urandom_range(0, 4) == 0)
                c.stamp = 32'd0;
        end
        else
        begin
            c.kind     = 1'($urandom);
            c.now_time = $urandom;
        end
        return c;
    endfunction

    task automatic send_cmd(body_cmd_t c);
        if (!steady && $urandom_range(0, 4) == 0)
        begin
            item_ch.valid <= 1'b0;
            repeat ($urandom_range(1, 11)) @(posedge clk);
        end
        item_ch.valid     <= 1'b1;
        item_ch.kind      <= c.kind;
        item_ch.vel_x     <= c.vel_x;
        item_ch.vel_y     <= c.vel_y;
        item_ch.yaw_rate  <= c.yaw_rate;
        item_ch.ref_valid <= c.ref_valid;
        item_ch.stamp     <= c.stamp;
        item_ch.now_time  <= c.now_time;
        @(posedge clk);
        while (item_ch.ready !== 1'b1)
            @(posedge clk);
        pending_wheels.insert(pending_wheels.size(), predict_wheels(c));
    endtask

    task automatic drain();
        item_ch.valid <= 1'b0;
        while (pending_wheels.size() != 0)
            @(posedge clk);
    endtask

    task automatic put_reg(cfg_reg_t idx, logic [31:0] data);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= data;
        @(posedge clk);
    endtask

    task automatic configure(input logic signed [15:0] c, s,
                             input logic signed [31:0] ox, oy,
                             input logic [30:0] ps, ir, input logic [31:0] tmo);
        drain();
        put_reg(REG_COS_OFFSET, 32'(c));
        put_reg(REG_SIN_OFFSET, 32'(s));
        put_reg(REG_BASE_OFF_X, ox);
        put_reg(REG_BASE_OFF_Y, oy);
        put_reg(REG_PROJ_SUM, {1'($urandom), ps});
        put_reg(REG_INV_RADIUS, {1'($urandom), ir});
        put_reg(REG_REF_TIMEOUT, tmo);
        cfg_we  <= 1'b0;
        cos_a   = c;
        sin_a   = s;
        off_x   = ox;
        off_y   = oy;
        proj    = ps;
        inv_r   = ir;
        ref_tmo = tmo;
    endtask

    // result side: random stall bursts, in-order compare
    initial
    begin
        int stall;
        wheel_out_t w;
        stall = 0;
        result_ch.ready = 1'b0;
        forever
        begin
            @(posedge clk);
            if (rst_n === 1'b1 && result_ch.valid === 1'b1 && result_ch.ready === 1'b1)
            begin
                if (pending_wheels.size() == 0)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                        $display("unexpected result transfer: status=%0d", result_ch.status);
                end
                else
                begin
                    w = pending_wheels.pop_front();
                    if (result_ch.wheel_front_left !== w.fl
                        || result_ch.wheel_front_right !== w.fr
                        || result_ch.wheel_rear_right !== w.rr
                        || result_ch.wheel_rear_left !== w.rl
                        || result_ch.status !== w.status)
                    begin
                        mismatches++;
                        if (mismatches <= 10)
                            $display({"mismatch: expected fl=%0d fr=%0d rr=%0d rl=%0d st=%0d",
                                      " got fl=%0d fr=%0d rr=%0d rl=%0d st=%0d"},
                                     w.fl, w.fr, w.rr, w.rl, w.status,
                                     result_ch.wheel_front_left, result_ch.wheel_front_right,
                                     result_ch.wheel_rear_right, result_ch.wheel_rear_left,
                                     result_ch.status);
                    end
                end
            end
            if (!steady && stall == 0 && $urandom_range(0, 5) == 0)
                stall = $urandom_range(1, 11);
            if (stall > 0)
            begin
                stall--;
                result_ch.ready <= 1'b0;
            end
            else
                result_ch.ready <= 1'b1;
        end
    end

    task automatic test_default_setup();
        send_cmd(tick_cmd(32'd100));
        send_cmd(ref_cmd(32'sd65536, 32'sd0, 32'sd0, 1'b1, 32'd0, 32'd100));
        send_cmd(tick_cmd(32'd100));
        send_cmd(tick_cmd(32'd101));
        send_cmd(tick_cmd(32'd102));
        send_cmd(ref_cmd(32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'd5, 32'd9));
        send_cmd(tick_cmd(32'd9));
        send_cmd(ref_cmd(32'h8000_0000, 32'h8000_0000, 32'h8000_0000, 1'b1, 32'd0,
                         32'hFFFF_FFFF));
        send_cmd(tick_cmd(32'hFFFF_FFFF));
        send_cmd(ref_cmd(32'sd1000, -32'sd1000, 32'sd7, 1'b0, 32'd3, 32'd4));
        send_cmd(tick_cmd(32'd4));
    endtask

    task automatic test_offset_extremes();
        configure(-16'sd16384, 16'sd16384, 32'h7FFF_FFFF, 32'h8000_0000,
                  31'h7FFF_FFFF, 31'h7FFF_FFFF, 32'hFFFF_FFFF);
        send_cmd(ref_cmd(32'sd70000, -32'sd3000, 32'sd12345, 1'b1, 32'd1, 32'd0));
        send_cmd(tick_cmd(32'h0001_2345));
        send_cmd(tick_cmd(32'h8000_0000));
        send_cmd(ref_cmd(32'h8000_0000, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 1'b1, 32'd0,
                         32'h5555_AAAA));
        send_cmd(tick_cmd(32'hAAAA_5555));
    endtask

    task automatic test_timeout_handling();
        logic [31:0] t0;
        t0 = $urandom;
        configure(16'sd16384, 16'sd0, 32'sd0, 32'sd0, 31'd65536, 31'd65536, 32'd10);
        send_cmd(ref_cmd(32'sd65536, 32'sd65536, 32'sd65536, 1'b1, t0 + 32'd5, t0));
        send_cmd(ref_cmd(32'sd65536, -32'sd65536, 32'sd32768, 1'b1, t0 - 32'd10, t0));
        send_cmd(tick_cmd(t0));
        send_cmd(tick_cmd(t0 + 32'd1));
        send_cmd(tick_cmd(t0 + 32'd1));
        send_cmd(ref_cmd(32'sd4096, 32'sd8192, -32'sd4096, 1'b1, 32'd0, t0 + 32'd2));
    endtask

    task automatic test_zero_radius();
        configure(16'sd11585, 16'sd11585, 32'sd20000, -32'sd20000, 31'd100000, 31'd0, 32'd0);
        send_cmd(ref_cmd(32'h7FFF_FFFF, 32'sd65536, -32'sd65536, 1'b1, 32'd0, 32'd77));
        send_cmd(tick_cmd(32'd80));
    endtask

    task automatic test_random_traffic();
        logic signed [15:0] c, s;
        logic [31:0] tmo;
        for (int phase = 0; phase < 6; phase++)
        begin
            c = ($urandom_range(0, 3) == 0) ? -16'sd16384 : 16'(int'($urandom_range(0, 32768)) - 16384);
            s = ($urandom_range(0, 3) == 0) ? 16'sd16384 : 16'(int'($urandom_range(0, 32768)) - 16384);
            case ($urandom_range(0, 5))
                0: tmo = 32'd0;
                1: tmo = 32'hFFFF_FFFF;
                2: tmo = $urandom;
                default: tmo = $urandom_range(1, 40);
            endcase
            configure(c, s, rand_wide(), rand_wide(),
                      ($urandom_range(0, 3) == 0) ? 31'($urandom) : 31'($urandom_range(0, 1 << 18)),
                      ($urandom_range(0, 4) == 0) ? 31'($urandom) : 31'($urandom_range(0, 1 << 18)),
                      tmo);
            if (phase == 5)
                steady = 1'b1;
            now_t = $urandom;
            repeat (258) send_cmd(random_cmd());
        end
    endtask

    initial
    begin
        rst_n              = 1'b0;
        cfg_we             = 1'b0;
        cfg_index          = '0;
        cfg_wdata          = '0;
        item_ch.valid      = 1'b0;
        item_ch.kind       = KIND_REF;
        item_ch.vel_x      = '0;
        item_ch.vel_y      = '0;
        item_ch.yaw_rate   = '0;
        item_ch.ref_valid  = 1'b0;
        item_ch.stamp      = '0;
        item_ch.now_time   = '0;
        cos_a              = 16'sd16384;
        sin_a              = '0;
        off_x              = '0;
        off_y              = '0;
        proj               = 31'd65536;
        inv_r              = 31'd65536;
        ref_tmo            = '0;
        held_vx            = '0;
        held_vy            = '0;
        held_yaw           = '0;
        held_stamp         = '0;
        held_ok            = 1'b0;
        now_t              = '0;
        repeat (7) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);
        test_default_setup();
        test_offset_extremes();
        test_timeout_handling();
        test_zero_radius();
        test_random_traffic();
        drain();
        repeat (30) @(posedge clk);
        if (mismatches == 0)
            $display("TEST PASSED");
        else
            $display("TEST FAILED");
        $finish;
    end

endmodule
